// ===== rtl/core/gn3_pkg.sv =====
// ============================================================================
// gn3_pkg
// Shared constants, permutation table and arithmetic helpers for the
// 3D gradient noise pipeline.
// ============================================================================
`default_nettype none

package gn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 24;
    localparam int FSH_R     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int FSH_L     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    typedef logic [7:0]         hash_t;
    typedef logic [15:0]        frac_t;
    typedef logic [16:0]        fade_t;
    typedef logic signed [16:0] dist_t;
    typedef logic signed [17:0] val_t;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    // Integer lattice cell of a coordinate, wrapped to 8 bits.
    function automatic hash_t cell_of(logic [COORD_W-1:0] c);
        return 8'(c >> FRAC_BITS);
    endfunction

    // Fraction of a coordinate brought to Q0.16.
    function automatic frac_t frac_of(logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] f;
        f = c & COORD_W'((1 << FRAC_BITS) - 1);
        if (FRAC_BITS >= 16)
            return 16'(f >> FSH_R);
        else
            return 16'(f << FSH_L);
    endfunction

    // Gradient dot product selected by the low nibble of a corner hash.
    function automatic val_t grad(hash_t h, dist_t x, dist_t y, dist_t z);
        val_t gx, gy, gz, r;
        gx = 18'(x);
        gy = 18'(y);
        gz = 18'(z);
        case (h[3:0])
            4'h0: r =  gx + gy;
            4'h1: r = -gx + gy;
            4'h2: r =  gx - gy;
            4'h3: r = -gx - gy;
            4'h4: r =  gx + gz;
            4'h5: r = -gx + gz;
            4'h6: r =  gx - gz;
            4'h7: r = -gx - gz;
            4'h8: r =  gy + gz;
            4'h9: r = -gy + gz;
            4'hA: r =  gy - gz;
            4'hB: r = -gy - gz;
            4'hC: r =  gy + gx;
            4'hD: r = -gy + gz;
            4'hE: r =  gy - gx;
            default: r = -gy - gz;
        endcase
        return r;
    endfunction

    // a + floor(w * (b - a) / 2^16); the result stays between a and b.
    function automatic val_t lerp(fade_t w, val_t a, val_t b);
        logic signed [18:0] diff;
        logic signed [36:0] prod;
        logic signed [20:0] s;
        diff = 19'(b) - 19'(a);
        prod = 37'(signed'({1'b0, w})) * 37'(diff);
        s    = 21'(a) + 21'(prod >>> 16);
        return s[17:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gn3_hash.sv =====
// ============================================================================
// gn3_hash
// Three-stage corner hash through the permutation table; carries the
// fractions along so that they line up with the hashes.
// ============================================================================
`default_nettype none

module gn3_hash
    import gn3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [COORD_W-1:0] coord_x,
    input  wire logic [COORD_W-1:0] coord_y,
    input  wire logic [COORD_W-1:0] coord_z,
    output hash_t                   hash [8],
    output frac_t                   tx,
    output frac_t                   ty,
    output frac_t                   tz
);

    hash_t px_reg [2];
    hash_t yi_reg, zi1_reg, zi2_reg;
    hash_t py_reg [4];
    hash_t h_reg  [8];
    frac_t t1_reg [3];
    frac_t t2_reg [3];
    frac_t t3_reg [3];

    // Stage 1 looks up the x cells, stage 2 adds y, stage 3 adds z.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= PERM[cell_of(coord_x)];
            px_reg[1] <= PERM[8'(cell_of(coord_x) + 8'd1)];
            yi_reg    <= cell_of(coord_y);
            zi1_reg   <= cell_of(coord_z);
            t1_reg[0] <= frac_of(coord_x);
            t1_reg[1] <= frac_of(coord_y);
            t1_reg[2] <= frac_of(coord_z);
            for (int c = 0; c < 4; c++)
                py_reg[c] <= PERM[8'(px_reg[c % 2] + yi_reg + 8'(c / 2))];
            zi2_reg <= zi1_reg;
            t2_reg  <= t1_reg;
            for (int c = 0; c < 8; c++)
                h_reg[c] <= PERM[8'(py_reg[c % 4] + zi2_reg + 8'(c / 4))];
            t3_reg <= t2_reg;
        end
    end

    assign hash = h_reg;
    assign tx   = t3_reg[0];
    assign ty   = t3_reg[1];
    assign tz   = t3_reg[2];

endmodule

`default_nettype wire

// ===== rtl/core/gn3_fade.sv =====
// ============================================================================
// gn3_fade
// Three-stage fade curve 6t^5 - 15t^4 + 10t^3 for one axis.
// ============================================================================
`default_nettype none

module gn3_fade
    import gn3_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire frac_t t,
    output fade_t     fade
);

    logic [31:0] t2_reg;
    frac_t       t1_reg;
    logic [31:0] t3s_reg;
    logic [20:0] ps_reg;
    fade_t       fade_reg;

    logic [47:0] t3;
    logic [37:0] p;
    logic [52:0] prod;

    always_comb
    begin
        t3   = 48'(t2_reg) * 48'(t1_reg);
        p    = 38'(t2_reg) * 38'd6 - ((38'(t1_reg) * 38'd15) << 16) + (38'd10 << 32);
        prod = 53'(t3s_reg) * 53'(ps_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg   <= 32'(t) * 32'(t);
            t1_reg   <= t;
            t3s_reg  <= t3[47:16];
            ps_reg   <= p[36:16];
            fade_reg <= prod[48:32];
        end
    end

    assign fade = fade_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gn3_blend.sv =====
// ============================================================================
// gn3_blend
// Gradient stage followed by the x, y and z blend stages and the output map.
// ============================================================================
`default_nettype none

module gn3_blend
    import gn3_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire hash_t  hash [8],
    input  wire frac_t  tx,
    input  wire frac_t  ty,
    input  wire frac_t  tz,
    input  wire fade_t  u,
    input  wire fade_t  v,
    input  wire fade_t  w,
    output logic [15:0] noise
);

    val_t        g_reg [8];
    fade_t       u4_reg, v4_reg, w4_reg, v5_reg, w5_reg, w6_reg;
    val_t        x_reg [4];
    val_t        y_reg [2];
    logic [15:0] noise_reg;

    dist_t       dx [2];
    dist_t       dy [2];
    dist_t       dz [2];
    val_t        n_lerp;
    logic signed [19:0] n;
    logic [18:0] r;
    logic [15:0] noise_next;

    always_comb
    begin
        // The far offset t - 1 is the fraction with the sign bit set.
        dx[0] = signed'({1'b0, tx});
        dx[1] = signed'({1'b1, tx});
        dy[0] = signed'({1'b0, ty});
        dy[1] = signed'({1'b1, ty});
        dz[0] = signed'({1'b0, tz});
        dz[1] = signed'({1'b1, tz});
        n_lerp = lerp(w6_reg, y_reg[0], y_reg[1]);
        n      = 20'(n_lerp) + 20'sd65536;
        r      = 19'(n >>> 1);
        if (n <= 0)
            noise_next = 16'd0;
        else if (r > 19'd65535)
            noise_next = 16'hFFFF;
        else
            noise_next = r[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 8; c++)
                g_reg[c] <= grad(hash[c], dx[c % 2], dy[(c / 2) % 2], dz[c / 4]);
            u4_reg <= u;
            v4_reg <= v;
            w4_reg <= w;
            for (int k = 0; k < 4; k++)
                x_reg[k] <= lerp(u4_reg, g_reg[2 * k], g_reg[2 * k + 1]);
            v5_reg <= v4_reg;
            w5_reg <= w4_reg;
            for (int k = 0; k < 2; k++)
                y_reg[k] <= lerp(v5_reg, x_reg[2 * k], x_reg[2 * k + 1]);
            w6_reg    <= w5_reg;
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gradient_noise_3d.sv =====
// ============================================================================
// gradient_noise_3d
// Improved 3D gradient noise: one fixed-point point in, one Q0.16 value out.
// ============================================================================
// Usage:
// The input channel carries coord_x, coord_y and coord_z, each unsigned with
// 8 integer and 16 fraction bits. A word is taken at a clock edge where
// in_valid is high and in_stall is low. The output channel carries
// noise_value, the noise mapped to 0..1 in unsigned Q0.16 and saturated; a
// word leaves where out_valid is high and out_stall is low.
// The pipeline has seven register stages: three for the permutation hash
// and fade curve, one for the gradients, one each for the x and y blends,
// and one for the z blend with the output mapping. One word is accepted
// every cycle while in_stall is low.
// When the receiver stalls while the last stage holds a finished word, every
// stage holds, bubbles included, and in_stall is raised so the input waits
// too. When the last stage is empty, out_stall has no effect and the pipe
// keeps moving.
// Reset clears the valid bits of every stage; data registers are not reset.
// ============================================================================
`default_nettype none

module gradient_noise_3d
    import gn3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [COORD_W-1:0] coord_x,
    input  wire logic [COORD_W-1:0] coord_y,
    input  wire logic [COORD_W-1:0] coord_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             noise_value
);

    localparam int DEPTH = 7;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    hash_t            hash [8];
    frac_t            tx, ty, tz;
    fade_t            u, v, w;

    // The whole pipe advances unless a finished word is held at the output.
    assign en       = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    gn3_hash u_hash
    (
        .clk     (clk),
        .en      (en),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .coord_z (coord_z),
        .hash    (hash),
        .tx      (tx),
        .ty      (ty),
        .tz      (tz)
    );

    gn3_fade u_fade_x
    (
        .clk  (clk),
        .en   (en),
        .t    (frac_of(coord_x)),
        .fade (u)
    );

    gn3_fade u_fade_y
    (
        .clk  (clk),
        .en   (en),
        .t    (frac_of(coord_y)),
        .fade (v)
    );

    gn3_fade u_fade_z
    (
        .clk  (clk),
        .en   (en),
        .t    (frac_of(coord_z)),
        .fade (w)
    );

    gn3_blend u_blend
    (
        .clk   (clk),
        .en    (en),
        .hash  (hash),
        .tx    (tx),
        .ty    (ty),
        .tz    (tz),
        .u     (u),
        .v     (v),
        .w     (w),
        .noise (noise_value)
    );

    assign out_valid = vld_reg[DEPTH-1];

endmodule

`default_nettype wire
